### rtl/button_debounce_long_press_led_mode_assert.svh
// Assertion macros used by the lane RTL. Clock is clk, reset is rst.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_LED_MODE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_LED_MODE_ASSERT_SVH

// Same-cycle implication.
`define BDLP_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

  // Button count and hold counter width
  localparam int NUM_BUTTONS = 3;
  localparam int HOLD_W      = 8;

  // Field widths
  localparam int BTN_FIELD_W = 3;
  localparam int LEVEL_W     = 8;
  localparam int DUTY_W      = 8;
  localparam int RELOAD_W    = 4;
  localparam int LIMIT_W     = 8;
  localparam int CHANNELS    = 3;
  localparam int CMP_W       = (HOLD_W > LIMIT_W) ? HOLD_W : LIMIT_W;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [RELOAD_W-1:0] RELOAD_RESET = RELOAD_W'(5);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(50);
  localparam logic [DUTY_W-1:0]   DUTY_FULL    = {DUTY_W{1'b1}};
  localparam logic [DUTY_W-1:0]   DUTY_OFF     = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_RELOAD  = 1'b0,
    REG_LONG_PRESS_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [BTN_FIELD_W-1:0] buttons_low;
    logic [LEVEL_W-1:0]     pot_level;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_a;
    logic [DUTY_W-1:0]   duty_b;
    logic [DUTY_W-1:0]   duty_c;
    logic [CHANNELS-1:0] analog_bits;
  } result_t;

  // What one lane reports after a tick
  typedef struct packed {
    logic              mode;
    logic [DUTY_W-1:0] duty;
  } lane_out_t;

endpackage

`default_nettype wire

### rtl/bdlp_lane.sv
`default_nettype none

`include "button_debounce_long_press_led_mode_assert.svh"

module bdlp_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic                           level,
  input  wire logic [bdlp_pkg::LEVEL_W-1:0]   pot,
  input  wire logic [bdlp_pkg::RELOAD_W-1:0]  reload,
  input  wire logic [bdlp_pkg::LIMIT_W-1:0]   limit,
  output bdlp_pkg::lane_out_t                 status
);

  logic                            held, held_next;
  logic                            settled, settled_next;
  logic                            pending, pending_next;
  logic                            mode, mode_next;
  logic [bdlp_pkg::RELOAD_W-1:0]   settle_count, settle_count_next;
  logic [bdlp_pkg::HOLD_W-1:0]     hold_count, hold_count_next;
  logic [bdlp_pkg::DUTY_W-1:0]     duty, duty_next;

  // Work out one tick of debounce, hold count and mode decision
  always_comb begin
    logic pressed;
    pressed           = ~level;
    held_next         = held;
    settled_next      = settled;
    pending_next      = pending;
    mode_next         = mode;
    settle_count_next = settle_count;
    hold_count_next   = hold_count;
    duty_next         = duty;

    // Press edge: start debounce, restart hold count
    if (!held_next && pressed) begin
      held_next         = 1'b1;
      settled_next      = 1'b0;
      settle_count_next = reload;
      hold_count_next   = '0;
    end
    // Count while held, saturate at the top
    if (held_next && (hold_count_next != {bdlp_pkg::HOLD_W{1'b1}})) begin
      hold_count_next = hold_count_next + 1'b1;
    end
    // Release edge after a settled press
    if (held_next && !pressed && settled_next) begin
      pending_next      = 1'b1;
      settled_next      = 1'b0;
      settle_count_next = reload;
    end
    // Count down, or finish the debounce
    if (settle_count_next != '0) begin
      settle_count_next = settle_count_next - 1'b1;
    end else begin
      settled_next = 1'b1;
      if (pending_next) begin
        pending_next = 1'b0;
        held_next    = 1'b0;
        if ((bdlp_pkg::CMP_W'(hold_count_next) > bdlp_pkg::CMP_W'(limit)) && !mode_next) begin
          mode_next = 1'b1;
          duty_next = pot;
        end else if (mode_next) begin
          mode_next = 1'b0;
          duty_next = bdlp_pkg::DUTY_FULL;
        end else begin
          duty_next = (duty_next == bdlp_pkg::DUTY_FULL) ? bdlp_pkg::DUTY_OFF
                                                         : bdlp_pkg::DUTY_FULL;
        end
      end
    end
    // Analog channels follow the reading
    if (mode_next) begin
      duty_next = pot;
    end
  end

  // Advance the lane state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      settled      <= 1'b1;
      pending      <= 1'b0;
      mode         <= 1'b0;
      settle_count <= '0;
      hold_count   <= '0;
      duty         <= bdlp_pkg::DUTY_FULL;
    end else if (step) begin
      held         <= held_next;
      settled      <= settled_next;
      pending      <= pending_next;
      mode         <= mode_next;
      settle_count <= settle_count_next;
      hold_count   <= hold_count_next;
      duty         <= duty_next;
    end
  end

  assign status.mode = mode_next;
  assign status.duty = duty_next;

  `BDLP_ASSERT_NOW(a_pending_held, pending, held, "release pending without a held button")
  `BDLP_ASSERT_NOW(a_settled_zero, settled, settle_count == '0, "settled with countdown running")
  `BDLP_ASSERT_NEXT(a_analog_follow, step && mode_next, duty == $past(pot),
                    "analog channel does not follow the reading")
  `BDLP_ASSERT_NEXT(a_idle_hold, !step, $stable(hold_count) && $stable(mode) && $stable(duty),
                    "lane state moved without a word")

endmodule

`default_nettype wire

### rtl/bdlp_merge.sv
`default_nettype none

module bdlp_merge (
  input  wire bdlp_pkg::lane_out_t  lanes [bdlp_pkg::NUM_BUTTONS],
  output bdlp_pkg::result_t         result
);

  logic [bdlp_pkg::DUTY_W-1:0] duty [bdlp_pkg::CHANNELS];
  logic [bdlp_pkg::CHANNELS-1:0] analog;

  // Map lanes to output channels; missing lanes read full duty, digital mode
  for (genvar ch = 0; ch < bdlp_pkg::CHANNELS; ch++) begin : g_chan
    if (ch < bdlp_pkg::NUM_BUTTONS) begin : g_lane
      assign duty[ch]   = lanes[ch].duty;
      assign analog[ch] = lanes[ch].mode;
    end else begin : g_none
      assign duty[ch]   = bdlp_pkg::DUTY_FULL;
      assign analog[ch] = 1'b0;
    end
  end

  assign result.duty_a      = duty[0];
  assign result.duty_b      = duty[1];
  assign result.duty_c      = duty[2];
  assign result.analog_bits = analog;

endmodule

`default_nettype wire

### rtl/button_debounce_long_press_led_mode.sv
// Three-button debounce with long-press detection driving three duty values.
// One input word is one timer tick; every lane updates its button in the cycle
// the word is accepted, so the block takes one word per clock while the skid
// register is empty and registers each result in the output register, or in the
// skid register while a result waits (a two-entry buffer that lets one more word
// in). Registers: index 0 is the debounce reload (4 bits, reset 5), index 1 the
// long-press limit (8 bits, reset 50); write them only while the block is idle.
`default_nettype none

module button_debounce_long_press_led_mode (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 item_valid,
  output logic                                      item_ready,
  input  wire bdlp_pkg::item_t                      item,
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output bdlp_pkg::result_t                         result,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bdlp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [bdlp_pkg::RELOAD_W-1:0] debounce_reload;
  logic [bdlp_pkg::LIMIT_W-1:0]  long_press_limit;
  logic                          accept, take;
  logic                          skid_valid;
  bdlp_pkg::result_t             skid, merged;
  bdlp_pkg::lane_out_t           lanes [bdlp_pkg::NUM_BUTTONS];

  assign cfg_ready  = 1'b1;
  assign item_ready = ~skid_valid;
  assign accept     = item_valid & item_ready;
  assign take       = result_valid & result_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_reload  <= bdlp_pkg::RELOAD_RESET;
      long_press_limit <= bdlp_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (bdlp_pkg::cfg_reg_e'(cfg_index))
        bdlp_pkg::REG_DEBOUNCE_RELOAD:  debounce_reload  <= cfg_data[bdlp_pkg::RELOAD_W-1:0];
        bdlp_pkg::REG_LONG_PRESS_LIMIT: long_press_limit <= cfg_data[bdlp_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  // One lane per button; buttons past the input field read pressed
  for (genvar i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin : g_lane
    logic level;
    if (i < bdlp_pkg::BTN_FIELD_W) begin : g_in
      assign level = item.buttons_low[i];
    end else begin : g_pad
      assign level = 1'b0;
    end

    bdlp_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .step   (accept),
      .level  (level),
      .pot    (item.pot_level),
      .reload (debounce_reload),
      .limit  (long_press_limit),
      .status (lanes[i])
    );
  end

  bdlp_merge u_merge (
    .lanes  (lanes),
    .result (merged)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      if (result_valid) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= merged;
      end
    end else if (accept) begin
      if (result_valid) begin
        skid <= merged;
      end else begin
        result <= merged;
      end
    end
  end

endmodule

`default_nettype wire
